@@ rtl/dcte_pkg.sv @@
package dcte_pkg;

   localparam logic [1:0] KIND_START   = 2'd0;
   localparam logic [1:0] KIND_BYTE    = 2'd1;
   localparam logic [1:0] KIND_TIMEOUT = 2'd2;

   localparam logic [1:0] ST_SUCCESS  = 2'd0;
   localparam logic [1:0] ST_TIMEOUT  = 2'd1;
   localparam logic [1:0] ST_CHECKSUM = 2'd2;
   localparam logic [1:0] ST_MISSING  = 2'd3;

   localparam logic [2:0] REG_PAD      = 3'd0;
   localparam logic [2:0] REG_STATUS   = 3'd1;
   localparam logic [2:0] REG_FAULT    = 3'd2;
   localparam logic [2:0] REG_SPEED    = 3'd3;
   localparam logic [2:0] REG_SELECTED = 3'd4;

   localparam logic [7:0] CH_STX = 8'h02;
   localparam logic [7:0] CH_CR  = 8'h0D;

   // work for the back end: send a telegram or emit a report
   typedef struct packed {
      logic        is_report;
      logic [1:0]  status;
      logic [7:0]  addr;
      logic [15:0] value;
   } job_type;

   function automatic logic [7:0] hex_char(input logic [3:0] d);
      hex_char = (d < 4'd10) ? (8'h30 + {4'd0, d}) : (8'h37 + {4'd0, d});
   endfunction

   function automatic logic [3:0] hex_val(input logic [7:0] c);
      logic [3:0] r;
      r = 4'd0;
      if (c >= 8'h30 && c <= 8'h39) r = c[3:0];
      else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66))
         r = c[3:0] + 4'd9;
      hex_val = r;
   endfunction

endpackage

@@ rtl/dcte_front.sv @@
module dcte_front #(
   parameter int MAX_ROUNDS = 3
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [2:0]           csr_index,
   input  logic [2:0]           csr_data,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [1:0]           req_kind,
   input  logic [15:0]          req_control_word,
   input  logic [15:0]          req_setpoint,
   input  logic [15:0]          req_extra_setpoint,
   input  logic [7:0]           req_rx_byte,
   output logic                 job_valid,
   input  logic                 job_ready,
   output dcte_pkg::job_type    job,
   output logic [63:0]          replies
);

   logic [2:0]  pad_ff, cst_ff, cfl_ff, csp_ff, csl_ff;
   logic        busy_ff, busy_in;
   logic [1:0]  tidx_ff, tidx_in;
   logic [1:0]  rnd_ff, rnd_in;
   logic [3:0]  seen_ff, seen_in;
   logic [15:0] rep_ff [4];
   logic [15:0] rep_in [4];
   logic [15:0] cmd_ff [3];
   logic [15:0] cmd_in [3];
   logic [3:0]  cnt_ff, cnt_in;
   logic [7:0]  sum_ff, sum_in;
   logic [7:0]  adr_ff, adr_in;
   logic [15:0] val_ff, val_in;
   logic        jv_ff, jv_in;
   dcte_pkg::job_type job_ff, job_in;

   logic        acc;
   logic        fire;
   logic [7:0]  bcc;
   logic [2:0]  code;
   logic [1:0]  slot;
   logic        hit;
   logic [1:0]  ntidx;
   logic [1:0]  nrnd;
   logic [3:0]  nseen;

   assign req_ready = !jv_ff || job_ready;
   assign acc       = req_valid && req_ready;
   assign job_valid = jv_ff;
   assign job       = job_ff;
   assign replies   = {rep_ff[3], rep_ff[2], rep_ff[1], rep_ff[0]};
   assign bcc       = (8'd0 - sum_ff) & 8'h7f;
   assign code      = adr_ff[2:0];

   always_comb begin
      hit = 1'b1;
      slot = 2'd0;
      if (code == cst_ff) slot = 2'd0;
      else if (code == cfl_ff) slot = 2'd1;
      else if (code == csp_ff) slot = 2'd2;
      else if (code == csl_ff) slot = 2'd3;
      else hit = 1'b0;
   end

   function automatic dcte_pkg::job_type tele(input logic [1:0] ti, input logic [2:0] pad,
                                               input logic [15:0] c0, input logic [15:0] c1,
                                               input logic [15:0] c2);
      dcte_pkg::job_type j;
      j = '0;
      case (ti)
         2'd1:    begin j.addr = {2'b0, pad, 3'd2}; j.value = c1; end
         2'd3:    begin j.addr = {2'b0, pad, 3'd3}; j.value = c2; end
         default: begin j.addr = {2'b0, pad, 3'd0}; j.value = c0; end
      endcase
      tele = j;
   endfunction

   always_comb begin
      busy_in = busy_ff;
      tidx_in = tidx_ff;
      rnd_in  = rnd_ff;
      seen_in = seen_ff;
      rep_in  = rep_ff;
      cmd_in  = cmd_ff;
      cnt_in  = cnt_ff;
      sum_in  = sum_ff;
      adr_in  = adr_ff;
      val_in  = val_ff;
      jv_in   = jv_ff && !job_ready;
      job_in  = job_ff;
      fire    = 1'b0;
      ntidx   = tidx_ff + 2'd1;
      nrnd    = rnd_ff + 2'd1;
      nseen   = seen_ff | (hit ? (4'd1 << slot) : 4'd0);
      if (acc) begin
         if (req_kind == dcte_pkg::KIND_START) begin
            cmd_in[0] = req_control_word;
            cmd_in[1] = req_setpoint;
            cmd_in[2] = req_extra_setpoint;
            busy_in = 1'b1;
            tidx_in = 2'd0;
            rnd_in  = 2'd0;
            seen_in = 4'd0;
            fire    = 1'b1;
            job_in  = tele(2'd0, pad_ff, req_control_word, req_setpoint,
                           req_extra_setpoint);
         end else if (busy_ff && req_kind == dcte_pkg::KIND_TIMEOUT) begin
            busy_in = 1'b0;
            cnt_in  = 4'd0;
            fire    = 1'b1;
            job_in  = '0;
            job_in.is_report = 1'b1;
            job_in.status = dcte_pkg::ST_TIMEOUT;
         end else if (busy_ff && req_kind == dcte_pkg::KIND_BYTE) begin
            if (cnt_ff >= 4'd1 && cnt_ff <= 4'd6) begin
               sum_in = sum_ff + req_rx_byte;
               if (cnt_ff <= 4'd2) adr_in = {adr_ff[3:0], dcte_pkg::hex_val(req_rx_byte)};
               else val_in = {val_ff[11:0], dcte_pkg::hex_val(req_rx_byte)};
            end
            if (cnt_ff < 4'd8) begin
               cnt_in = cnt_ff + 4'd1;
            end else begin
               cnt_in = 4'd0;
               fire   = 1'b1;
               job_in = '0;
               job_in.is_report = 1'b1;
               if (req_rx_byte != bcc) begin
                  busy_in = 1'b0;
                  job_in.status = dcte_pkg::ST_CHECKSUM;
               end else begin
                  if (hit) rep_in[slot] = val_ff;
                  seen_in = nseen;
                  tidx_in = ntidx;
                  if (ntidx == 2'd0) rnd_in = nrnd;
                  if (ntidx == 2'd0 && nseen == 4'hf) begin
                     busy_in = 1'b0;
                     job_in.status = dcte_pkg::ST_SUCCESS;
                  end else if (ntidx == 2'd0 && 32'(nrnd) >= MAX_ROUNDS) begin
                     busy_in = 1'b0;
                     job_in.status = dcte_pkg::ST_MISSING;
                  end else begin
                     job_in = tele(ntidx, pad_ff, cmd_ff[0], cmd_ff[1], cmd_ff[2]);
                  end
               end
            end
         end
         if (fire && !job_in.is_report) begin
            cnt_in = 4'd0;
            sum_in = 8'd0;
            adr_in = 8'd0;
            val_in = 16'd0;
         end
         if (fire) jv_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pad_ff  <= 3'd1;
         cst_ff  <= 3'd0;
         cfl_ff  <= 3'd1;
         csp_ff  <= 3'd4;
         csl_ff  <= 3'd5;
         busy_ff <= 1'b0;
         tidx_ff <= 2'd0;
         rnd_ff  <= 2'd0;
         seen_ff <= 4'd0;
         cnt_ff  <= 4'd0;
         sum_ff  <= 8'd0;
         adr_ff  <= 8'd0;
         val_ff  <= 16'd0;
         jv_ff   <= 1'b0;
         for (int i = 0; i < 4; i++) rep_ff[i] <= 16'd0;
         for (int i = 0; i < 3; i++) cmd_ff[i] <= 16'd0;
      end else begin
         busy_ff <= busy_in;
         tidx_ff <= tidx_in;
         rnd_ff  <= rnd_in;
         seen_ff <= seen_in;
         cnt_ff  <= cnt_in;
         sum_ff  <= sum_in;
         adr_ff  <= adr_in;
         val_ff  <= val_in;
         jv_ff   <= jv_in;
         rep_ff  <= rep_in;
         cmd_ff  <= cmd_in;
         if (csr_we) begin
            unique case (csr_index)
               dcte_pkg::REG_PAD:      pad_ff <= csr_data;
               dcte_pkg::REG_STATUS:   cst_ff <= csr_data;
               dcte_pkg::REG_FAULT:    cfl_ff <= csr_data;
               dcte_pkg::REG_SPEED:    csp_ff <= csr_data;
               dcte_pkg::REG_SELECTED: csl_ff <= csr_data;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      job_ff <= job_in;
   end

   a_cnt_range: assert property (@(posedge clock) disable iff (reset) cnt_ff <= 4'd8)
      else $error("rx count out of range");
   a_idle_cnt: assert property (@(posedge clock) disable iff (reset)
      !busy_ff |-> cnt_ff == 4'd0)
      else $error("rx count nonzero while idle");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      job_valid && !job_ready |=> job_valid && $stable(job_ff))
      else $error("job dropped while stalled");

endmodule

@@ rtl/dcte_back.sv @@
module dcte_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 job_valid,
   output logic                 job_ready,
   input  dcte_pkg::job_type    job,
   input  logic [63:0]          replies,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic                 rsp_out_kind,
   output logic [7:0]           rsp_tx_byte,
   output logic                 rsp_last,
   output logic [1:0]           rsp_status,
   output logic [15:0]          rsp_status_word,
   output logic [15:0]          rsp_fault_word,
   output logic [15:0]          rsp_speed_actual,
   output logic [15:0]          rsp_selected_actual
);

   logic [3:0]  pos_ff, pos_in;
   logic [7:0]  bcc;
   logic [7:0]  c1, c2, c3, c4, c5, c6;
   logic [7:0]  byte_sel;
   logic        done;

   assign c1 = dcte_pkg::hex_char(job.addr[7:4]);
   assign c2 = dcte_pkg::hex_char(job.addr[3:0]);
   assign c3 = dcte_pkg::hex_char(job.value[15:12]);
   assign c4 = dcte_pkg::hex_char(job.value[11:8]);
   assign c5 = dcte_pkg::hex_char(job.value[7:4]);
   assign c6 = dcte_pkg::hex_char(job.value[3:0]);
   assign bcc = (8'd0 - (c1 + c2 + c3 + c4 + c5 + c6)) & 8'h7f;

   always_comb begin
      case (pos_ff)
         4'd0:    byte_sel = dcte_pkg::CH_STX;
         4'd1:    byte_sel = c1;
         4'd2:    byte_sel = c2;
         4'd3:    byte_sel = c3;
         4'd4:    byte_sel = c4;
         4'd5:    byte_sel = c5;
         4'd6:    byte_sel = c6;
         4'd7:    byte_sel = dcte_pkg::CH_CR;
         default: byte_sel = bcc;
      endcase
   end

   assign done      = job.is_report || pos_ff == 4'd8;
   assign rsp_valid = job_valid;
   assign job_ready = rsp_ready && done;
   assign rsp_out_kind = job.is_report;
   assign rsp_tx_byte  = job.is_report ? 8'd0 : byte_sel;
   assign rsp_last     = done;
   assign rsp_status   = job.is_report ? job.status : 2'd0;
   assign rsp_status_word     = job.is_report ? replies[15:0]  : 16'd0;
   assign rsp_fault_word      = job.is_report ? replies[31:16] : 16'd0;
   assign rsp_speed_actual    = job.is_report ? replies[47:32] : 16'd0;
   assign rsp_selected_actual = job.is_report ? replies[63:48] : 16'd0;

   always_comb begin
      pos_in = pos_ff;
      if (job_valid && rsp_ready) pos_in = done ? 4'd0 : pos_ff + 4'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) pos_ff <= 4'd0;
      else pos_ff <= pos_in;
   end

   a_pos: assert property (@(posedge clock) disable iff (reset) pos_ff <= 4'd8)
      else $error("byte position out of range");
   a_rep_pos: assert property (@(posedge clock) disable iff (reset)
      job_valid && job.is_report |-> pos_ff == 4'd0)
      else $error("report mid telegram");
   a_idle_pos: assert property (@(posedge clock) disable iff (reset)
      !job_valid |-> pos_ff == 4'd0)
      else $error("position set without job");

endmodule

@@ rtl/drive_cyclic_telegram_exchange.sv @@
// channel | direction | handshake           | payload
// req     | in        | req_valid/req_ready | kind, command words, rx byte
// rsp     | out       | rsp_valid/rsp_ready | tx byte or finished report
// csr     | in        | csr_we              | csr_index, csr_data
// A start, a busy timeout or a ninth byte queues one job; all wait on req_ready.
// A telegram job is 9 rsp transfers, one per cycle with rsp_ready; a report is one.
// Input stalls only while a queued job is waiting and the back end is not finishing it.
// Reset is synchronous and active high; the pending job is dropped.
module drive_cyclic_telegram_exchange #(
   parameter int MAX_ROUNDS = 3
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [2:0]  csr_data,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_kind,
   input  logic [15:0] req_control_word,
   input  logic [15:0] req_setpoint,
   input  logic [15:0] req_extra_setpoint,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_out_kind,
   output logic [7:0]  rsp_tx_byte,
   output logic        rsp_last,
   output logic [1:0]  rsp_status,
   output logic [15:0] rsp_status_word,
   output logic [15:0] rsp_fault_word,
   output logic [15:0] rsp_speed_actual,
   output logic [15:0] rsp_selected_actual
);

   logic              job_valid;
   logic              job_ready;
   dcte_pkg::job_type job;
   logic [63:0]       replies;

   dcte_front #(.MAX_ROUNDS(MAX_ROUNDS)) u_front (
      .clock, .reset, .csr_we, .csr_index, .csr_data,
      .req_valid, .req_ready, .req_kind, .req_control_word, .req_setpoint,
      .req_extra_setpoint, .req_rx_byte,
      .job_valid, .job_ready, .job, .replies
   );

   dcte_back u_back (
      .clock, .reset, .job_valid, .job_ready, .job, .replies,
      .rsp_valid, .rsp_ready, .rsp_out_kind, .rsp_tx_byte, .rsp_last, .rsp_status,
      .rsp_status_word, .rsp_fault_word, .rsp_speed_actual, .rsp_selected_actual
   );

endmodule
